/* src/bve_pkg.sv */
`timescale 1ns / 1ps
package bve_pkg;
    localparam int DefWindowDepth = 5;
    localparam int TimeW = 32;
    localparam int VelW  = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_SPAN,
        ST_DIV,
        ST_SFIN,
        ST_TERM_INIT,
        ST_POW,
        ST_BINOM,
        ST_RD,
        ST_ACC,
        ST_NEXT,
        ST_SAT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic        op;
        logic [31:0] t;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] ix;
        logic [31:0] iy;
        logic [31:0] iz;
        logic        rv;
    } t_out_beat;

    function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] res;
        res = v;
        if (v > 64'sd2147483647) res = 64'sd2147483647;
        else if (v < -64'sd2147483648) res = -64'sd2147483648;
        return res;
    endfunction

    function automatic logic [7:0] binom8(input logic [2:0] n, input logic [2:0] k);
        logic [7:0] tbl [0:7][0:7];
        logic [7:0] res;
        for (int a = 0; a < 8; a++)
            for (int b = 0; b < 8; b++)
                tbl[a][b] = 8'd0;
        for (int a = 0; a < 8; a++) begin
            tbl[a][0] = 8'd1;
            for (int b = 1; b <= a; b++)
                tbl[a][b] = tbl[a-1][b-1] + tbl[a-1][b];
        end
        res = tbl[n][k];
        return res;
    endfunction
endpackage

/* src/bve_if.sv */
`timescale 1ns / 1ps
interface bve_in_if;
    logic                valid;
    logic                ready;
    bve_pkg::t_in_beat   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bve_out_if;
    logic                valid;
    logic                ready;
    bve_pkg::t_out_beat  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/bezier_velocity_extrapolator_unit.sv */
`timescale 1ns / 1ps
// Bezier velocity extrapolator. A push beat (opcode 0) stores one reading in a
// WINDOW_DEPTH-entry ring and returns no result. A query beat (opcode 1)
// returns one result beat: s is formed by a 49-step restoring divider, then each
// of the n+1 Bernstein weights is built by n repeated Q16.16 multiplies on one
// shared 32x32 multiplier, scaled by its binomial coefficient and applied to the
// three axes in turn. With fewer than two readings, or a zero span, the query
// returns early with an all-zero result beat.
module bezier_velocity_extrapolator_unit #(
    parameter int WINDOW_DEPTH = bve_pkg::DefWindowDepth
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bve_in_if.sink    i_in,
    bve_out_if.source o_out
);
    import bve_pkg::*;
    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);

    t_state r_state, n_state;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_head;
    t_in_beat      r_in;
    logic [AW-1:0] w_ram_waddr, w_ram_raddr;
    logic [127:0]  w_rdata;
    logic          w_we;

    logic [AW-1:0] r_raddr;
    logic [2:0]    r_n, r_l, r_k;
    logic [1:0]    r_ax;
    logic signed [31:0] r_newt, r_s, r_r;
    logic signed [63:0] r_w, r_prod;
    logic signed [63:0] r_sum [3];
    logic          r_mul_pend, r_div_start;
    t_out_beat     r_out;
    logic          r_oval;
    logic          w_div_done;
    logic signed [63:0] w_quot;
    logic signed [32:0] w_dq;
    logic signed [33:0] w_span;
    logic signed [31:0] w_mul_a, w_mul_b;
    logic signed [63:0] w_mul;
    logic [CW-1:0] w_newidx;

    function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
        logic [AW:0] x;
        x = v;
        if (x >= (AW+1)'(WINDOW_DEPTH)) x = x - (AW+1)'(WINDOW_DEPTH);
        return x[AW-1:0];
    endfunction

    assign w_we = (r_state == ST_PUSH);
    assign w_newidx = (r_count == CW'(WINDOW_DEPTH)) ? CW'(0) : r_count;
    assign w_ram_waddr = wrap({1'b0, r_head} + (AW+1)'(w_newidx));
    assign w_ram_raddr = r_raddr;

    bve_ram #(.Width(128), .Depth(WINDOW_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_ram_waddr),
        .i_wdata({r_in.t, r_in.vx, r_in.vy, r_in.vz}),
        .i_raddr(w_ram_raddr), .o_rdata(w_rdata)
    );

    assign w_dq = $signed({1'b0, r_in.t}) - $signed({1'b0, r_newt});
    assign w_span = $signed({2'b0, r_newt}) - $signed({2'b0, w_rdata[127:96]});

    bve_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_start),
        .i_num(w_dq), .i_den(w_span), .o_done(w_div_done), .o_quot(w_quot)
    );

    assign w_mul_a = r_w[31:0];
    always_comb begin
        w_mul_b = (r_k < (r_n - r_l)) ? r_r : r_s;
        if (r_state == ST_ACC) begin
            case (r_ax)
                2'd0:    w_mul_b = w_rdata[95:64];
                2'd1:    w_mul_b = w_rdata[63:32];
                default: w_mul_b = w_rdata[31:0];
            endcase
        end
    end
    assign w_mul = w_mul_a * w_mul_b;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in.valid && i_in.ready)
                n_state = i_in.data.op ? ST_SPAN : ST_PUSH;
            ST_PUSH: n_state = ST_IDLE;
            ST_SPAN: n_state = (r_count < CW'(2)) ? ST_OUT : ST_DIV;
            ST_DIV:  if (r_div_start && w_span == 34'sd0) n_state = ST_OUT;
                     else if (w_div_done && !r_div_start && r_k == 3'd3) n_state = ST_SFIN;
            ST_SFIN: n_state = ST_TERM_INIT;
            ST_TERM_INIT: n_state = ST_POW;
            ST_POW:  if (!r_mul_pend && r_k == r_n) n_state = ST_BINOM;
            ST_BINOM: n_state = ST_RD;
            ST_RD:   n_state = ST_ACC;
            ST_ACC:  if (r_mul_pend && r_ax == 2'd2) n_state = ST_NEXT;
            ST_NEXT: n_state = (r_l == r_n) ? ST_SAT : ST_TERM_INIT;
            ST_SAT:  n_state = ST_OUT;
            ST_OUT:  if (o_out.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign i_in.ready = (r_state == ST_IDLE);
    assign o_out.valid = r_oval;
    assign o_out.data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_count <= '0; r_head <= '0;
            r_oval <= 1'b0; r_mul_pend <= 1'b0; r_div_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_div_start <= (r_state == ST_DIV) && (r_k == 3'd2);
            if (r_state == ST_IDLE && i_in.valid) r_in <= i_in.data;
            if (r_state == ST_PUSH) begin
                if (r_count == CW'(WINDOW_DEPTH)) r_head <= wrap({1'b0, r_head} + 1'b1);
                else r_count <= r_count + 1'b1;
            end
            case (r_state)
                ST_SPAN: begin
                    r_out <= '0;
                    r_n <= 3'(r_count - 1'b1);
                    r_raddr <= wrap({1'b0, r_head} + (AW+1)'(r_count - 1'b1));
                    r_k <= 3'd0;
                end
                ST_DIV: begin
                    case (r_k)
                        3'd0: begin
                            r_raddr <= r_head;
                            r_k <= 3'd1;
                        end
                        3'd1: begin
                            r_newt <= w_rdata[127:96];
                            r_k <= 3'd2;
                        end
                        3'd2: r_k <= 3'd3;
                        default: ;
                    endcase
                end
                ST_SFIN: begin
                    r_s <= 32'(sat32(w_quot));
                    r_r <= 32'(sat32(64'sd65536 - sat32(w_quot)));
                    r_l <= 3'd0;
                    r_sum[0] <= '0; r_sum[1] <= '0; r_sum[2] <= '0;
                end
                ST_TERM_INIT: begin
                    r_w <= 64'sd65536; r_k <= 3'd0; r_mul_pend <= 1'b0;
                end
                ST_POW: if (r_k != r_n) begin
                    if (!r_mul_pend) begin
                        r_prod <= w_mul; r_mul_pend <= 1'b1;
                    end else begin
                        r_w <= sat32(r_prod / 64'sd65536);
                        r_k <= r_k + 1'b1; r_mul_pend <= 1'b0;
                    end
                end
                ST_BINOM: begin
                    r_w <= sat32(r_w * $signed({56'd0, binom8(r_n, r_l)}));
                    r_raddr <= wrap({1'b0, r_head} + (AW+1)'(r_n - r_l));
                    r_ax <= 2'd0;
                end
                ST_ACC: begin
                    if (!r_mul_pend) begin
                        r_prod <= w_mul; r_mul_pend <= 1'b1;
                    end else begin
                        r_sum[r_ax] <= r_sum[r_ax] + r_prod / 64'sd65536;
                        r_ax <= r_ax + 1'b1; r_mul_pend <= 1'b0;
                    end
                end
                ST_NEXT: r_l <= r_l + 1'b1;
                ST_SAT: begin
                    r_out.ix <= 32'(sat32(r_sum[0]));
                    r_out.iy <= 32'(sat32(r_sum[1]));
                    r_out.iz <= 32'(sat32(r_sum[2]));
                    r_out.rv <= 1'b1;
                end
                default: ;
            endcase
            if (r_state == ST_DIV && r_div_start && w_span == 34'sd0) r_out <= '0;
            if (n_state == ST_OUT && r_state != ST_OUT) r_oval <= 1'b1;
            else if (r_state == ST_OUT && o_out.ready) r_oval <= 1'b0;
        end
    end

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid)) else $error("in and out busy together");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(WINDOW_DEPTH)) else $error("count overflow");
    a_valid_lt2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_count < CW'(2)) |-> !o_out.data.rv) else $error("bad valid");
endmodule

/* src/bve_ram.sv */
`timescale 1ns / 1ps
module bve_ram #(
    parameter int Width = 8,
    parameter int Depth = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* src/bve_div.sv */
`timescale 1ns / 1ps
module bve_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [32:0]  i_num,
    input  logic signed [33:0]  i_den,
    output logic                o_done,
    output logic signed [63:0]  o_quot
);
    import bve_pkg::*;
    logic [48:0] r_rem_n, n_rem_n;
    logic [49:0] r_acc, n_acc;
    logic [48:0] r_q, n_q;
    logic [33:0] r_d, n_d;
    logic        r_neg, n_neg;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [49:0] w_try;
    logic [48:0] w_num_abs;
    logic [33:0] w_den_abs;

    assign w_num_abs = i_num[32] ? 49'((-$signed({{16{i_num[32]}}, i_num, 16'd0}) >>> 16) <<< 16)
                                 : 49'({i_num, 16'd0});
    assign w_den_abs = i_den[33] ? 34'(-i_den) : 34'(i_den);
    assign w_try = {r_acc[48:0], r_rem_n[48]} - {16'd0, r_d};

    always_comb begin
        n_rem_n = r_rem_n; n_acc = r_acc; n_q = r_q; n_d = r_d;
        n_neg = r_neg; n_cnt = r_cnt; n_busy = r_busy;
        if (i_start) begin
            n_rem_n = w_num_abs; n_acc = '0; n_q = '0; n_d = w_den_abs;
            n_neg = i_num[32] ^ i_den[33]; n_cnt = 6'd49; n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem_n = {r_rem_n[47:0], 1'b0};
            if (!w_try[49]) begin
                n_acc = w_try;
                n_q = {r_q[47:0], 1'b1};
            end else begin
                n_acc = {r_acc[48:0], r_rem_n[48]};
                n_q = {r_q[47:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_cnt <= n_cnt;
        end
        r_rem_n <= n_rem_n; r_acc <= n_acc; r_q <= n_q; r_d <= n_d; r_neg <= n_neg;
    end

    assign o_done = r_busy && r_cnt == 6'd1;
    assign o_quot = r_neg ? -$signed({15'd0, n_q}) : $signed({15'd0, n_q});
endmodule

/* tb/sv/tb_bezier_velocity_extrapolator_unit.sv */
`timescale 1ns / 1ps
module tb_bezier_velocity_extrapolator_unit;
    import bve_pkg::*;

    localparam int Depth = DefWindowDepth;
    localparam int QOne = 65536;
    localparam logic OpPush = 1'b0;
    localparam logic OpQuery = 1'b1;
    localparam longint CycleLimit = 2_000_000;
    localparam int ExpDepth = 16;

    class velocity_scoreboard;
        logic [31:0] times [Depth];
        longint vels [Depth][3];
        int count;
        t_out_beat exp_q [ExpDepth];
        int exp_wr;
        int exp_rd;
        int errors;

        function new();
            count = 0;
            errors = 0;
            exp_wr = 0;
            exp_rd = 0;
        endfunction

        function int outstanding();
            return exp_wr - exp_rd;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint choose(int n, int k);
            longint c;
            c = 1;
            for (int i = 0; i < k; i++) c = c * (n - i) / (i + 1);
            return c;
        endfunction

        function void note_input(t_in_beat b);
            t_out_beat e;
            longint dq, span, s, r, w;
            longint acc [3];
            int n;
            if (b.op == OpPush) begin
                if (count >= Depth) begin
                    for (int i = 1; i < Depth; i++) begin
                        times[i-1] = times[i];
                        vels[i-1] = vels[i];
                    end
                    count = Depth - 1;
                end
                times[count] = b.t;
                vels[count][0] = longint'(signed'(b.vx));
                vels[count][1] = longint'(signed'(b.vy));
                vels[count][2] = longint'(signed'(b.vz));
                count++;
                return;
            end
            e = '0;
            if (count >= 2) begin
                n = count - 1;
                span = longint'(times[n]) - longint'(times[0]);
                if (span != 0) begin
                    dq = longint'(b.t) - longint'(times[n]);
                    s = clamp32((dq * QOne) / span);
                    r = clamp32(QOne - s);
                    acc = '{0, 0, 0};
                    for (int l = 0; l <= n; l++) begin
                        w = QOne;
                        for (int k = 0; k < n - l; k++) w = clamp32((w * r) / QOne);
                        for (int k = 0; k < l; k++) w = clamp32((w * s) / QOne);
                        w = clamp32(w * choose(n, l));
                        for (int a = 0; a < 3; a++) acc[a] += (vels[n-l][a] * w) / QOne;
                    end
                    e.ix = 32'(clamp32(acc[0]));
                    e.iy = 32'(clamp32(acc[1]));
                    e.iz = 32'(clamp32(acc[2]));
                    e.rv = 1'b1;
                end
            end
            if (outstanding() >= ExpDepth) begin
                $display("%0t: expected results overflow", $time);
                errors++;
                return;
            end
            exp_q[exp_wr % ExpDepth] = e;
            exp_wr++;
        endfunction

        function void check_result(t_out_beat got);
            t_out_beat e;
            if (outstanding() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = exp_q[exp_rd % ExpDepth];
            exp_rd++;
            if (got.ix !== e.ix) begin
                $display("%0t: interp_x expected %h actual %h", $time, e.ix, got.ix);
                errors++;
            end
            if (got.iy !== e.iy) begin
                $display("%0t: interp_y expected %h actual %h", $time, e.iy, got.iy);
                errors++;
            end
            if (got.iz !== e.iz) begin
                $display("%0t: interp_z expected %h actual %h", $time, e.iz, got.iz);
                errors++;
            end
            if (got.rv !== e.rv) begin
                $display("%0t: result_valid expected %b actual %b", $time, e.rv, got.rv);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bve_in_if in_ch ();
    bve_out_if out_ch ();
    velocity_scoreboard board = new();
    int send_idle_pct = 37;
    int recv_idle_pct = 54;
    longint cycles = 0;
    logic [31:0] last_time = 0;

    bezier_velocity_extrapolator_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) board.check_result(out_ch.data);
        if (i_rst_n && in_ch.valid && in_ch.ready) board.note_input(in_ch.data);
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_beat(t_in_beat b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic push_reading(logic [31:0] t, logic [31:0] x, logic [31:0] y,
                                logic [31:0] z);
        t_in_beat b;
        b.op = OpPush;
        b.t = t;
        b.vx = x;
        b.vy = y;
        b.vz = z;
        send_beat(b);
        last_time = t;
    endtask

    task automatic query_at(logic [31:0] t);
        t_in_beat b;
        b.op = OpQuery;
        b.t = t;
        b.vx = $urandom;
        b.vy = $urandom;
        b.vz = $urandom;
        send_beat(b);
    endtask

    function automatic logic [31:0] rand_vel();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(20 * QOne)) - 10 * QOne);
        endcase
    endfunction

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic random_phase(int items);
        int done;
        done = 0;
        while (done < items) begin
            if ($urandom_range(9) < 6) begin
                push_reading(last_time + $urandom_range(100_000, 1),
                             rand_vel(), rand_vel(), rand_vel());
            end else begin
                case ($urandom_range(9))
                    0: query_at($urandom);
                    1: push_reading($urandom, rand_vel(), rand_vel(), rand_vel());
                    2: push_reading(last_time, rand_vel(), rand_vel(), rand_vel());
                    default: query_at(last_time + $urandom_range(300_000) - 100_000);
                endcase
            end
            done++;
            if ($urandom_range(99) == 0) drain();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        query_at(32'd1000);
        push_reading(32'd1000, 32'h00010000, 32'hffff0000, 32'h0);
        query_at(32'd1500);
        push_reading(32'd1000, 32'h7fffffff, 32'h80000000, 32'h1);
        query_at(32'd2000);
        push_reading(32'd3000, 32'h80000000, 32'h7fffffff, 32'hffffffff);
        query_at(32'd3000);
        query_at(32'd4000);
        query_at(32'hffffffff);
        query_at(32'd0);
        push_reading(32'd2000, 32'h00020000, 32'h00030000, 32'h00040000);
        push_reading(32'd5000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        push_reading(32'hffffffff, 32'h80000000, 32'h80000000, 32'h80000000);
        query_at(32'hffffffff);
        query_at(32'h7fffffff);
        push_reading(32'h00000000, 32'h00010000, 32'h00010000, 32'h00010000);
        push_reading(32'd10, 32'h12345678, 32'hedcba987, 32'h0);
        query_at(32'd20);
        query_at(32'hfffffff0);
        drain();
        random_phase(350);
        drain();
        send_idle_pct = 54;
        recv_idle_pct = 37;
        random_phase(350);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(300);
        drain();
        repeat (300) @(posedge i_clk);
        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

/* files.f */
src/bve_pkg.sv
src/bve_if.sv
src/bve_ram.sv
src/bve_div.sv
src/bezier_velocity_extrapolator_unit.sv
tb/sv/tb_bezier_velocity_extrapolator_unit.sv
